FILE: sv/gsig_pkg.sv
// Shared types, constants and helpers of the grid strip index generator.
// No dependencies; the register file, the walker, the top level and the bench import this package.
package gsig_pkg;

  localparam int unsigned MAX_DIM    = 256;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned BAND_W     = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  // Register index taken from the word address bit
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    PH_STITCH = 3'd0,
    PH_FIRST  = 3'd1,
    PH_BACK   = 3'd2,
    PH_SECOND = 3'd3,
    PH_TAIL1  = 3'd4,
    PH_TAIL2  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } dims_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             last_index;
    logic             exhausted;
  } out_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: sv/gsig_in_if.sv
// Request channel of the grid strip index generator: valid/ready plus restart.
// Depends on nothing.
interface gsig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

FILE: sv/gsig_out_if.sv
// Result channel of the grid strip index generator: valid/ready plus index fields.
// Depends on nothing.
interface gsig_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_index;
  logic        last_index;
  logic        exhausted;

  modport source (output valid, output vertex_index, output last_index,
                  output exhausted, input ready);
  modport sink   (input valid, input vertex_index, input last_index,
                  input exhausted, output ready);
endinterface

FILE: sv/gsig_cfg.sv
// APB-style register file holding cols and rows, with clamped copies out.
// Depends on gsig_pkg.
module gsig_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gsig_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gsig_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gsig_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output gsig_pkg::dims_t                    dims
);
  import gsig_pkg::*;

  logic [DIM_W-1:0] cols_r;
  logic [DIM_W-1:0] rows_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= DIM_RESET;
      rows_r <= DIM_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COLS: cols_r <= pwdata[DIM_W-1:0];
        REG_ROWS: rows_r <= pwdata[DIM_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLS: prdata = CFG_DATA_W'(cols_r);
      REG_ROWS: prdata = CFG_DATA_W'(rows_r);
      default:  prdata = '0;
    endcase
  end

  assign dims.cols = clamp_dim(cols_r);
  assign dims.rows = clamp_dim(rows_r);

endmodule

FILE: sv/gsig_step.sv
// Strip walker: state registers and the one-step index/next-state logic.
// Depends on gsig_pkg.
module gsig_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 restart,
  input  gsig_pkg::dims_t      dims,
  output gsig_pkg::out_item_t  result
);
  import gsig_pkg::*;

  logic [BAND_W-1:0] band_r,  band_nxt;
  logic [DIM_W-1:0]  col_r,   col_nxt;
  logic [IDX_W-1:0]  cur_r,   cur_nxt;
  phase_t            phase_r, phase_nxt;
  logic              half_r,  half_nxt;
  logic              first_r, first_nxt;
  logic              done_r,  done_nxt;

  logic [DIM_W-1:0]  half_cols;
  logic [IDX_W-1:0]  cols_ext;
  logic              do_body;

  assign half_cols = {1'b0, dims.cols[DIM_W-1:1]};
  assign cols_ext  = IDX_W'(dims.cols);

  always_comb begin
    band_nxt  = band_r;
    col_nxt   = col_r;
    cur_nxt   = cur_r;
    phase_nxt = phase_r;
    half_nxt  = half_r;
    first_nxt = first_r;
    done_nxt  = done_r;
    do_body   = 1'b1;
    result    = '{vertex_index: '0, last_index: 1'b0, exhausted: 1'b0};

    if (restart) begin
      band_nxt  = '0;
      col_nxt   = '0;
      cur_nxt   = '0;
      phase_nxt = PH_STITCH;
      half_nxt  = 1'b0;
      first_nxt = 1'b1;
      done_nxt  = 1'b0;
    end

    if (done_nxt) begin
      result.exhausted = 1'b1;
    end else begin
      // Stitch: repeat the band's first vertex, except in the first band
      if (phase_nxt == PH_STITCH) begin
        phase_nxt = PH_FIRST;
        half_nxt  = 1'b0;
        col_nxt   = '0;
        if (!first_nxt) begin
          result.vertex_index = cur_nxt;
          do_body             = 1'b0;
        end
      end

      if (do_body) begin
        case (phase_nxt)
          PH_FIRST: begin
            if (!half_nxt) begin
              result.vertex_index = cur_nxt;
              half_nxt            = 1'b1;
            end else begin
              result.vertex_index = cur_nxt + cols_ext;
              half_nxt            = 1'b0;
              cur_nxt             = cur_nxt + IDX_W'(1);
              col_nxt             = col_nxt + DIM_W'(1);
              if (col_nxt >= half_cols) phase_nxt = PH_BACK;
            end
          end
          PH_BACK: begin
            cur_nxt             = cur_nxt - IDX_W'(1);
            result.vertex_index = cur_nxt + cols_ext;
            col_nxt             = half_cols - DIM_W'(1);
            half_nxt            = 1'b0;
            phase_nxt           = PH_SECOND;
          end
          PH_SECOND: begin
            if (!half_nxt) begin
              result.vertex_index = cur_nxt + cols_ext;
              half_nxt            = 1'b1;
            end else begin
              result.vertex_index = cur_nxt;
              half_nxt            = 1'b0;
              cur_nxt             = cur_nxt + IDX_W'(1);
              col_nxt             = col_nxt + DIM_W'(1);
              if (col_nxt >= dims.cols) phase_nxt = PH_TAIL1;
            end
          end
          PH_TAIL1: begin
            result.vertex_index = cur_nxt - IDX_W'(1);
            phase_nxt           = PH_TAIL2;
          end
          PH_TAIL2: begin
            result.vertex_index = cur_nxt - IDX_W'(1);
            band_nxt            = band_nxt + BAND_W'(1);
            first_nxt           = 1'b0;
            phase_nxt           = PH_STITCH;
            if (band_nxt == '0 || {1'b0, band_nxt} >= dims.rows - DIM_W'(1)) begin
              result.last_index = 1'b1;
              done_nxt          = 1'b1;
            end
          end
          default: begin
            // Unused phase codes end the sequence
            done_nxt         = 1'b1;
            result.exhausted = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r  <= '0;
      col_r   <= '0;
      cur_r   <= '0;
      phase_r <= PH_STITCH;
      half_r  <= 1'b0;
      first_r <= 1'b1;
      done_r  <= 1'b1;
    end else if (advance) begin
      band_r  <= band_nxt;
      col_r   <= col_nxt;
      cur_r   <= cur_nxt;
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      first_r <= first_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

FILE: sv/grid_strip_index_generator.sv
// Grid strip index generator, top level.
// An accepted request's result is loaded into the output register in the cycle after acceptance.
// Throughput: one request per cycle while the sink takes each result; the walker state steps once per request.
// The output register frees itself in the cycle it is taken, so no bubble appears.
// Reset (rst_n low, synchronous): cols = rows = 16, no result pending, sequence idle
// until a request with restart set; requests before that return exhausted.
module grid_strip_index_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  gsig_in_if.sink                         in_ch,
  gsig_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gsig_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [gsig_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [gsig_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import gsig_pkg::*;

  dims_t     dims;
  out_item_t step_res;
  out_item_t out_r;
  logic      out_valid_r;
  logic      accept;

  // Take a new request whenever the output register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Hold cols/rows; the walker only ever sees clamped dimensions
  gsig_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .dims    (dims)
  );

  // Advance the strip walker by one index per accepted request
  gsig_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .restart (in_ch.restart),
    .dims    (dims),
    .result  (step_res)
  );

  // Result register: load on accept, drop valid once the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_r.vertex_index;
  assign out_ch.last_index   = out_r.last_index;
  assign out_ch.exhausted    = out_r.exhausted;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_strip_index_generator: step requests in, strip indices out.
// Depends on gsig_pkg, the two channel interfaces and the top-level RTL module.
module tb;
  import gsig_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // byte addresses of the two registers, one 32-bit word each
  localparam logic [CFG_ADDR_W-1:0] ADDR_COLS = CFG_ADDR_W'(4 * REG_COLS);
  localparam logic [CFG_ADDR_W-1:0] ADDR_ROWS = CFG_ADDR_W'(4 * REG_ROWS);

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gsig_in_if  in_ch ();
  gsig_out_if out_ch ();

  grid_strip_index_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Request stream waiting for the driver: one restart flag per step request
  logic      pending_restart[$];
  // Strip indices the block owes us, oldest first
  out_item_t expected_indices[$];

  // Copy of the dimension registers as last written
  logic [DIM_W-1:0] cols_setting;
  logic [DIM_W-1:0] rows_setting;

  // Strip walker state of the predictor
  logic [BAND_W-1:0] walk_band;
  logic [DIM_W-1:0]  walk_col;
  logic [IDX_W-1:0]  walk_pos;
  phase_t            walk_phase;
  logic              walk_odd;
  logic              walk_first;
  logic              walk_done;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  logic        req_taken;
  int unsigned items_in_flight;
  int unsigned items_queued;
  int unsigned idle_cycles;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_strips_done;
  int unsigned n_exhausted;
  int unsigned n_cfg_writes;
  int unsigned n_mismatch;
  out_item_t   oldest;
  out_item_t   predicted;

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 30) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Saturate a dimension register into the range the walker works with
  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic int unsigned strip_length();
    int unsigned c;
    int unsigned r;
    c = dim_in_use(cols_setting);
    r = dim_in_use(rows_setting);
    return (2 * (c + 1) + 4) * (r - 1) - 1;
  endfunction

  task automatic rewind_walker(input logic idle);
    walk_band  = '0;
    walk_col   = '0;
    walk_pos   = '0;
    walk_phase = PH_STITCH;
    walk_odd   = 1'b0;
    walk_first = 1'b1;
    walk_done  = idle;
  endtask

  // Advance the walker by one step request and return the index it yields
  task automatic predict_strip_index(input logic restart, output out_item_t res);
    int unsigned c;
    int unsigned r;
    int unsigned half;
    int unsigned idx;
    logic        last;
    logic        stitched;
    c        = dim_in_use(cols_setting);
    r        = dim_in_use(rows_setting);
    half     = c / 2;
    idx      = 0;
    last     = 1'b0;
    stitched = 1'b0;
    res      = '0;
    if (restart) rewind_walker(1'b0);
    if (walk_done || walk_phase > PH_TAIL2) begin
      walk_done     = 1'b1;
      res.exhausted = 1'b1;
    end else begin
      if (walk_phase == PH_STITCH) begin
        walk_phase = PH_FIRST;
        walk_odd   = 1'b0;
        walk_col   = '0;
        // every band after the first opens with a repeated stitch index
        if (!walk_first) begin
          idx      = walk_pos;
          stitched = 1'b1;
        end
      end
      if (!stitched) begin
        case (walk_phase)
          PH_FIRST: begin
            if (!walk_odd) begin
              idx      = walk_pos;
              walk_odd = 1'b1;
            end else begin
              idx      = walk_pos + c;
              walk_odd = 1'b0;
              walk_pos = walk_pos + 1'b1;
              walk_col = walk_col + 1'b1;
              if (walk_col >= half) walk_phase = PH_BACK;
            end
          end
          PH_BACK: begin
            walk_pos   = walk_pos - 1'b1;
            idx        = walk_pos + c;
            walk_col   = DIM_W'(half - 1);
            walk_odd   = 1'b0;
            walk_phase = PH_SECOND;
          end
          PH_SECOND: begin
            if (!walk_odd) begin
              idx      = walk_pos + c;
              walk_odd = 1'b1;
            end else begin
              idx      = walk_pos;
              walk_odd = 1'b0;
              walk_pos = walk_pos + 1'b1;
              walk_col = walk_col + 1'b1;
              if (walk_col >= c) walk_phase = PH_TAIL1;
            end
          end
          PH_TAIL1: begin
            idx        = walk_pos - 1;
            walk_phase = PH_TAIL2;
          end
          default: begin
            idx        = walk_pos - 1;
            walk_band  = walk_band + 1'b1;
            walk_first = 1'b0;
            walk_phase = PH_STITCH;
            if (walk_band == 0 || walk_band >= r - 1) begin
              last      = 1'b1;
              walk_done = 1'b1;
            end
          end
        endcase
      end
      res.vertex_index = idx[IDX_W-1:0];
      res.last_index   = last;
    end
  endtask

  // Request driver: hold a request until taken, else maybe launch the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !req_taken) begin
      // hold the current request
    end else if (pending_restart.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
      in_ch.valid   <= 1'b1;
      in_ch.restart <= pending_restart.pop_front();
    end else begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'($urandom_range(0, 1));
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor: predict on each taken request, check each taken result, run the watchdog
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req_taken = 1'b1;
        n_requests++;
        items_in_flight--;
        predict_strip_index(in_ch.restart, predicted);
        expected_indices.push_back(predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_indices.size() == 0) begin
          report_mismatch($sformatf("result index %0d with no request outstanding",
                                    out_ch.vertex_index));
        end else begin
          oldest = expected_indices.pop_front();
          if (oldest.last_index) n_strips_done++;
          if (oldest.exhausted) n_exhausted++;
          if (out_ch.vertex_index !== oldest.vertex_index)
            report_mismatch($sformatf("result %0d: vertex_index %0d, want %0d", n_results,
                                      out_ch.vertex_index, oldest.vertex_index));
          if (out_ch.last_index !== oldest.last_index)
            report_mismatch($sformatf("result %0d: last_index %b, want %b", n_results,
                                      out_ch.last_index, oldest.last_index));
          if (out_ch.exhausted !== oldest.exhausted)
            report_mismatch($sformatf("result %0d: exhausted %b, want %b", n_results,
                                      out_ch.exhausted, oldest.exhausted));
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, expected_indices.size());
      $display("grid_strip_index_generator test failed");
      $finish;
    end
  end

  task automatic queue_request(input logic restart);
    pending_restart.push_back(restart);
    items_in_flight++;
    items_queued++;
  endtask

  // Wait until every queued request is taken and its index has come back
  task automatic wait_drained();
    while (items_in_flight != 0 || expected_indices.size() != 0) @(negedge clk);
  endtask

  // Register write with a setup phase and an access phase; upper data bits carry noise the register drops
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= ($urandom & ~CFG_DATA_W'(9'h1FF)) | CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_COLS) cols_setting = value;
    else rows_setting = value;
    n_cfg_writes++;
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] c, input logic [DIM_W-1:0] r);
    write_reg(ADDR_COLS, c);
    write_reg(ADDR_ROWS, r);
  endtask

  // Pick grid dimensions: mostly small, now and then saturating or wide/tall extremes
  task automatic pick_dims();
    int unsigned sel;
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] r;
    sel = $urandom_range(0, 19);
    case (sel)
      0: begin
        c = ($urandom_range(0, 2) == 0) ? 9'd256 : 9'($urandom_range(257, 511));
        r = 9'($urandom_range(0, 2));
      end
      1: begin
        c = 9'($urandom_range(0, 2));
        r = 9'($urandom_range(0, 2));
      end
      2: begin
        c = 9'($urandom_range(0, 3));
        r = 9'($urandom_range(20, 40));
      end
      default: begin
        c = 9'($urandom_range(0, 12));
        r = 9'($urandom_range(0, 6));
      end
    endcase
    write_dims(c, r);
  endtask

  // Queue strips under the current dimensions: mostly complete, some cut short, some without a restart
  task automatic queue_strips(input int unsigned n_strips);
    int unsigned len;
    int unsigned kind;
    len = strip_length();
    repeat (n_strips) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        queue_request(1'b1);
        repeat (len - 1) queue_request(1'b0);
        // overrun the end to see exhausted
        repeat ($urandom_range(0, 2)) queue_request(1'b0);
      end else if (kind < 9) begin
        queue_request(1'b1);
        repeat ($urandom_range(1, len - 1)) queue_request(1'b0);
      end else begin
        // advance without a restart, continuing whatever state is left
        repeat ($urandom_range(1, 3)) queue_request(1'b0);
      end
    end
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input int unsigned budget);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < budget) begin
      pick_dims();
      // some batches run at full rate so bursts without gaps show up too
      if ($urandom_range(0, 5) == 0) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end else begin
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
      end
      queue_strips((strip_length() > 400) ? 1 : 3);
      // sender pauses here until every index has come back
      wait_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    cols_setting  = DIM_RESET;
    rows_setting  = DIM_RESET;
    rewind_walker(1'b1);
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    req_taken       = 1'b0;
    items_in_flight = 0;
    items_queued    = 0;
    idle_cycles     = 0;
    n_requests      = 0;
    n_results       = 0;
    n_strips_done   = 0;
    n_exhausted     = 0;
    n_cfg_writes    = 0;
    n_mismatch      = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Advance before any restart: the walker is idle and must report exhausted
    repeat (2) queue_request(1'b0);
    wait_drained();

    // Smallest grid: full strip, overrun, restart mid-strip, full strip again
    write_dims(9'd2, 9'd2);
    queue_request(1'b1);
    repeat (8) queue_request(1'b0);
    repeat (2) queue_request(1'b0);
    queue_request(1'b1);
    repeat (2) queue_request(1'b0);
    queue_request(1'b1);
    repeat (8) queue_request(1'b0);
    wait_drained();

    // Tall narrow grid: band counter climbs through many bands
    write_dims(9'd2, 9'd12);
    queue_request(1'b1);
    repeat (strip_length()) queue_request(1'b0);
    wait_drained();

    // Saturated dimensions, partial strip, then shrink the grid mid-strip
    write_dims(9'd511, 9'd511);
    queue_request(1'b1);
    repeat (120) queue_request(1'b0);
    wait_drained();
    write_dims(9'd5, 9'd3);
    repeat (40) queue_request(1'b0);
    wait_drained();

    run_phase(0, 0, 130);
    run_phase(83, 0, 130);
    run_phase(0, 83, 130);
    run_phase(20, 20, 130);

    wait_drained();
    repeat (10) @(negedge clk);
    if (expected_indices.size() != 0)
      report_mismatch($sformatf("%0d indices never arrived", expected_indices.size()));

    $display("Covered %0d step requests and %0d checked indices over %0d register writes.",
             n_requests, n_results, n_cfg_writes);
    $display("Strips run to their last index: %0d; exhausted replies: %0d; mismatches: %0d.",
             n_strips_done, n_exhausted, n_mismatch);
    if (n_mismatch == 0) begin
      $display("grid_strip_index_generator test passed");
    end else begin
      $display("grid_strip_index_generator test failed");
    end
    $finish;
  end

endmodule

FILE: grid_strip_index_generator.f
sv/gsig_pkg.sv
sv/gsig_in_if.sv
sv/gsig_out_if.sv
sv/gsig_cfg.sv
sv/gsig_step.sv
sv/grid_strip_index_generator.sv
dv/tb.sv
